// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the WAV deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/wpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// WAV deframer package
// Types, tags and codes shared by the WAV PCM16 deframer modules.
// ----------------------------------------------------------------------------
package wpsd_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_KEEP    = 32'd16;
  localparam logic [15:0] FMT_PCM     = 16'd1;
  localparam logic [15:0] BITS_PCM16  = 16'd16;
  localparam logic [15:0] CHAN_MONO   = 16'd1;
  localparam logic [15:0] CHAN_STEREO = 16'd2;

  localparam logic [3:0] RIFF_TAG_LAST = 4'd3;
  localparam logic [3:0] RIFF_HDR_LAST = 4'd11;
  localparam logic [3:0] CHDR_TAG_LEN  = 4'd4;
  localparam logic [3:0] CHDR_HDR_LAST = 4'd7;

  typedef enum logic [1:0] {
    KIND_FRAME  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REJ_NOT_WAVE   = 2'd0,
    REJ_NO_FMT     = 2'd1,
    REJ_NOT_PCM16  = 2'd2,
    REJ_BAD_CHAN   = 2'd3
  } reject_t;

  typedef enum logic [6:0] {
    PH_RIFF = 7'b000_0001,
    PH_CHDR = 7'b000_0010,
    PH_FMT  = 7'b000_0100,
    PH_SKIP = 7'b000_1000,
    PH_PAD  = 7'b001_0000,
    PH_DATA = 7'b010_0000,
    PH_DONE = 7'b100_0000
  } phase_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [31:0]        rate_hz;
    logic [15:0]        channel_count;
    logic [31:0]        data_length;
    reject_t            reject_reason;
    logic               last_frame;
  } result_t;

  function automatic logic [31:0] put_byte32(logic [31:0] v, logic [1:0] pos, logic [7:0] b);
    logic [31:0] r;
    r = v;
    unique case (pos)
      2'd0: r[7:0]   = b;
      2'd1: r[15:8]  = b;
      2'd2: r[23:16] = b;
      2'd3: r[31:24] = b;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/wpsd_parser.sv =====
// ----------------------------------------------------------------------------
// WAV deframer parser
// Holds the parse state and turns one file byte into at most one result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wpsd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              start_of_file,
  output wpsd_pkg::result_t res
);
  import wpsd_pkg::*;

  phase_t      phase, phase_c, phase_next;
  logic [3:0]  hdr_idx, hdr_idx_c, hdr_idx_next;
  logic [31:0] chunk_tag, chunk_tag_c, chunk_tag_next;
  logic [31:0] chunk_length, chunk_length_c, chunk_length_next;
  logic [31:0] bytes_remaining, bytes_remaining_c, bytes_remaining_next;
  logic [15:0] audio_format, audio_format_c, audio_format_next;
  logic [15:0] stored_channels, stored_channels_c, stored_channels_next;
  logic [31:0] stored_rate, stored_rate_c, stored_rate_next;
  logic [15:0] stored_bits, stored_bits_c, stored_bits_next;
  logic        format_seen, format_seen_c, format_seen_next;
  logic [23:0] frame_hold, frame_hold_c, frame_hold_next;
  logic [1:0]  frame_idx, frame_idx_c, frame_idx_next;

  logic [31:0] fmt_pos;
  logic [31:0] rem_dec;
  logic [2:0]  frame_size;
  logic [2:0]  frame_idx_inc;
  logic [23:0] hold_base;
  logic [31:0] word;

  logic        hdr_out;
  logic        rej_out;
  logic        last_out;

  always_comb begin
    phase_c           = start_of_file ? PH_RIFF : phase;
    hdr_idx_c         = start_of_file ? '0 : hdr_idx;
    chunk_tag_c       = start_of_file ? '0 : chunk_tag;
    chunk_length_c    = start_of_file ? '0 : chunk_length;
    bytes_remaining_c = start_of_file ? '0 : bytes_remaining;
    audio_format_c    = start_of_file ? '0 : audio_format;
    stored_channels_c = start_of_file ? '0 : stored_channels;
    stored_rate_c     = start_of_file ? '0 : stored_rate;
    stored_bits_c     = start_of_file ? '0 : stored_bits;
    format_seen_c     = start_of_file ? 1'b0 : format_seen;
    frame_hold_c      = start_of_file ? '0 : frame_hold;
    frame_idx_c       = start_of_file ? '0 : frame_idx;

    phase_next           = phase_c;
    hdr_idx_next         = hdr_idx_c;
    chunk_tag_next       = chunk_tag_c;
    chunk_length_next    = chunk_length_c;
    bytes_remaining_next = bytes_remaining_c;
    audio_format_next    = audio_format_c;
    stored_channels_next = stored_channels_c;
    stored_rate_next     = stored_rate_c;
    stored_bits_next     = stored_bits_c;
    format_seen_next     = format_seen_c;
    frame_hold_next      = frame_hold_c;
    frame_idx_next       = frame_idx_c;

    res.valid         = 1'b0;
    res.kind          = KIND_FRAME;
    res.left_sample   = '0;
    res.right_sample  = '0;
    res.rate_hz       = '0;
    res.channel_count = '0;
    res.data_length   = '0;
    res.reject_reason = REJ_NOT_WAVE;
    res.last_frame    = 1'b0;

    fmt_pos       = chunk_length_c - bytes_remaining_c;
    rem_dec       = bytes_remaining_c - 32'd1;
    frame_size    = (stored_channels_c == CHAN_STEREO) ? 3'd4 : 3'd2;
    frame_idx_inc = {1'b0, frame_idx_c} + 3'd1;
    hold_base     = (frame_idx_c == 2'd0) ? 24'd0 : frame_hold_c;
    word          = {8'd0, hold_base} | ({24'd0, data_byte} << {frame_idx_c, 3'b000});

    unique case (phase_c)
      PH_RIFF: begin
        chunk_tag_next = {chunk_tag_c[23:0], data_byte};
        if (hdr_idx_c == RIFF_TAG_LAST) begin
          chunk_length_next = (chunk_tag_next == TAG_RIFF) ? 32'd1 : 32'd0;
        end
        if (hdr_idx_c >= RIFF_HDR_LAST) begin
          hdr_idx_next = '0;
          if (chunk_tag_next == TAG_WAVE && chunk_length_c == 32'd1) begin
            chunk_length_next = '0;
            phase_next        = PH_CHDR;
          end else begin
            phase_next        = PH_DONE;
            res.valid         = 1'b1;
            res.kind          = KIND_REJECT;
            res.reject_reason = REJ_NOT_WAVE;
          end
        end else begin
          hdr_idx_next = hdr_idx_c + 4'd1;
        end
      end
      PH_CHDR: begin
        if (hdr_idx_c < CHDR_TAG_LEN) begin
          chunk_tag_next = {chunk_tag_c[23:0], data_byte};
          if (hdr_idx_c == 4'd0) begin
            chunk_length_next = '0;
          end
          hdr_idx_next = hdr_idx_c + 4'd1;
        end else begin
          chunk_length_next = put_byte32(chunk_length_c, hdr_idx_c[1:0], data_byte);
          if (hdr_idx_c >= CHDR_HDR_LAST) begin
            hdr_idx_next         = '0;
            bytes_remaining_next = chunk_length_next;
            if (chunk_tag_c == TAG_FMT) begin
              if (chunk_length_next == 32'd0) begin
                format_seen_next = 1'b1;
                phase_next       = PH_CHDR;
              end else begin
                phase_next = PH_FMT;
              end
            end else if (chunk_tag_c == TAG_DATA) begin
              phase_next = PH_DONE;
              res.valid  = 1'b1;
              res.kind   = KIND_REJECT;
              priority if (!format_seen_c) begin
                res.reject_reason = REJ_NO_FMT;
              end else if (audio_format_c != FMT_PCM || stored_bits_c != BITS_PCM16) begin
                res.reject_reason = REJ_NOT_PCM16;
              end else if (stored_channels_c != CHAN_MONO &&
                           stored_channels_c != CHAN_STEREO) begin
                res.reject_reason = REJ_BAD_CHAN;
              end else begin
                phase_next        = PH_DATA;
                frame_hold_next   = '0;
                frame_idx_next    = '0;
                res.kind          = KIND_HEADER;
                res.rate_hz       = stored_rate_c;
                res.channel_count = stored_channels_c;
                res.data_length   = chunk_length_next;
              end
            end else begin
              phase_next = (chunk_length_next == 32'd0) ? PH_CHDR : PH_SKIP;
            end
          end else begin
            hdr_idx_next = hdr_idx_c + 4'd1;
          end
        end
      end
      PH_FMT: begin
        if (fmt_pos < FMT_KEEP) begin
          unique case (fmt_pos[3:0])
            4'd0:    audio_format_next[7:0]     = data_byte;
            4'd1:    audio_format_next[15:8]    = data_byte;
            4'd2:    stored_channels_next[7:0]  = data_byte;
            4'd3:    stored_channels_next[15:8] = data_byte;
            4'd4:    stored_rate_next[7:0]      = data_byte;
            4'd5:    stored_rate_next[15:8]     = data_byte;
            4'd6:    stored_rate_next[23:16]    = data_byte;
            4'd7:    stored_rate_next[31:24]    = data_byte;
            4'd14:   stored_bits_next[7:0]      = data_byte;
            4'd15:   stored_bits_next[15:8]     = data_byte;
            default: ;
          endcase
        end
        bytes_remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          format_seen_next = 1'b1;
          phase_next       = PH_CHDR;
        end
      end
      PH_SKIP: begin
        bytes_remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_next = chunk_length_c[0] ? PH_PAD : PH_CHDR;
        end
      end
      PH_PAD: begin
        phase_next = PH_CHDR;
      end
      PH_DATA: begin
        if (frame_idx_c == 2'd0 && bytes_remaining_c < {29'd0, frame_size}) begin
          phase_next = PH_DONE;
        end else begin
          bytes_remaining_next = rem_dec;
          if (frame_idx_inc >= frame_size) begin
            frame_hold_next  = '0;
            frame_idx_next   = '0;
            res.valid        = 1'b1;
            res.kind         = KIND_FRAME;
            res.left_sample  = word[15:0];
            res.right_sample = (frame_size == 3'd4) ? word[31:16] : word[15:0];
            if (rem_dec < {29'd0, frame_size}) begin
              res.last_frame = 1'b1;
              phase_next     = PH_DONE;
            end
          end else begin
            frame_hold_next = word[23:0];
            frame_idx_next  = frame_idx_inc[1:0];
          end
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_RIFF;
      hdr_idx         <= '0;
      chunk_tag       <= '0;
      chunk_length    <= '0;
      bytes_remaining <= '0;
      audio_format    <= '0;
      stored_channels <= '0;
      stored_rate     <= '0;
      stored_bits     <= '0;
      format_seen     <= 1'b0;
      frame_hold      <= '0;
      frame_idx       <= '0;
    end else if (step) begin
      phase           <= phase_next;
      hdr_idx         <= hdr_idx_next;
      chunk_tag       <= chunk_tag_next;
      chunk_length    <= chunk_length_next;
      bytes_remaining <= bytes_remaining_next;
      audio_format    <= audio_format_next;
      stored_channels <= stored_channels_next;
      stored_rate     <= stored_rate_next;
      stored_bits     <= stored_bits_next;
      format_seen     <= format_seen_next;
      frame_hold      <= frame_hold_next;
      frame_idx       <= frame_idx_next;
    end
  end

  assign hdr_out  = step && res.valid && res.kind == KIND_HEADER;
  assign rej_out  = step && res.valid && res.kind == KIND_REJECT;
  assign last_out = step && res.valid && res.last_frame;

  `ASSERT_NEXT(a_hdr_to_data, clk, rst, hdr_out, phase == PH_DATA, "header without data phase")
  `ASSERT_NEXT(a_reject_stops, clk, rst, rej_out, phase == PH_DONE, "reject did not stop parsing")
  `ASSERT_NEXT(a_last_frame_stops, clk, rst, last_out, phase == PH_DONE, "last frame did not stop")

endmodule

// ===== rtl/wav_pcm16_stream_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// WAV PCM16 stream deframer
// Parses a byte stream of a RIFF/WAVE file into a header word and stereo frames, or a rejection.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle and gives at most one result word
// per byte: a rejection when the RIFF header or the data chunk header ends,
// a header word when the data chunk header ends, and then a stereo frame each
// time a whole PCM16 frame has arrived. A byte passes through an input
// register and then a result register, and a new byte is taken every cycle
// while the result side keeps up. Raising start_of_file with a byte restarts
// parsing with that byte as the first byte of a new file.
`include "assert_macros.svh"

module wav_pcm16_stream_deframer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               start_of_file,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample,
  output logic [31:0]        rate_hz,
  output logic [15:0]        channel_count,
  output logic [31:0]        data_length,
  output logic [1:0]         reject_reason,
  output logic               last_frame
);
  import wpsd_pkg::*;

  logic    s1_valid;
  logic [7:0] s1_byte;
  logic    s1_sof;
  logic    advance;
  result_t res;
  result_t out_r;
  logic    res_load;
  logic    out_stall;
  logic    out_not_frame;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_sof  <= start_of_file;
    end
  end

  wpsd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .data_byte     (s1_byte),
    .start_of_file (s1_sof),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_r <= res;
    end
  end

  assign kind          = out_r.kind;
  assign left_sample   = out_r.left_sample;
  assign right_sample  = out_r.right_sample;
  assign rate_hz       = out_r.rate_hz;
  assign channel_count = out_r.channel_count;
  assign data_length   = out_r.data_length;
  assign reject_reason = out_r.reject_reason;
  assign last_frame    = out_r.last_frame;

  assign res_load      = advance && res.valid;
  assign out_stall     = out_valid && !out_ready;
  assign out_not_frame = out_valid && out_r.kind != KIND_FRAME;

  `ASSERT_NEXT(a_result_registered, clk, rst, res_load, out_valid, "result not registered")
  `ASSERT_IMPLY(a_no_overrun, clk, rst, s1_valid && out_stall, !in_ready, "taken while stalled")
  `ASSERT_IMPLY(a_last_only_on_frame, clk, rst, out_not_frame, !last_frame, "last flag off a frame")

endmodule

// ===== verif/wav_deframer_predict_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WAV deframer prediction and check
// Watches both channels of the WAV PCM16 deframer, parses every accepted byte
// with its own copy of the parser state, and compares each result word with
// the oldest word it has predicted.
// ----------------------------------------------------------------------------
module wav_deframer_predict_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               start_of_file,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         kind,
  input  logic signed [15:0] left_sample,
  input  logic signed [15:0] right_sample,
  input  logic [31:0]        rate_hz,
  input  logic [15:0]        channel_count,
  input  logic [31:0]        data_length,
  input  logic [1:0]         reject_reason,
  input  logic               last_frame,
  output int                 mismatch_total,
  output int                 words_due
);
  import wpsd_pkg::*;

  phase_t      phase;
  logic [3:0]  hdr_count;
  logic [31:0] tag_shift;
  logic [31:0] chunk_len;
  logic [31:0] left_to_go;
  logic [15:0] fmt_code;
  logic [15:0] chans;
  logic [31:0] rate;
  logic [15:0] bits;
  logic        fmt_seen;
  logic [23:0] partial;
  logic [1:0]  frame_pos;

  result_t     due_words[$];
  int          bad_fields = 0;

  initial begin
    mismatch_total = 0;
    words_due = 0;
  end

  task automatic reset_parser();
    phase = PH_RIFF;
    hdr_count = '0;
    tag_shift = '0;
    chunk_len = '0;
    left_to_go = '0;
    fmt_code = '0;
    chans = '0;
    rate = '0;
    bits = '0;
    fmt_seen = 1'b0;
    partial = '0;
    frame_pos = '0;
  endtask

  task automatic parse_wav_byte(input logic [7:0] b, input logic mark,
                                output logic made, output result_t w);
    logic [31:0] pos;
    logic [31:0] joined;
    int          fsize;
    if (mark) begin
      reset_parser();
    end
    made = 1'b0;
    w = '0;
    w.valid = 1'b1;
    case (phase)
      PH_RIFF: begin
        tag_shift = {tag_shift[23:0], b};
        if (hdr_count == RIFF_TAG_LAST) begin
          chunk_len = (tag_shift == TAG_RIFF) ? 32'd1 : 32'd0;
        end
        if (hdr_count >= RIFF_HDR_LAST) begin
          hdr_count = '0;
          if (tag_shift == TAG_WAVE && chunk_len == 32'd1) begin
            chunk_len = '0;
            phase = PH_CHDR;
          end else begin
            phase = PH_DONE;
            w.kind = KIND_REJECT;
            w.reject_reason = REJ_NOT_WAVE;
            made = 1'b1;
          end
        end else begin
          hdr_count++;
        end
      end
      PH_CHDR: begin
        if (hdr_count < CHDR_TAG_LEN) begin
          tag_shift = {tag_shift[23:0], b};
          if (hdr_count == 4'd0) begin
            chunk_len = '0;
          end
          hdr_count++;
        end else begin
          chunk_len[8 * (hdr_count - CHDR_TAG_LEN) +: 8] = b;
          if (hdr_count >= CHDR_HDR_LAST) begin
            hdr_count = '0;
            left_to_go = chunk_len;
            if (tag_shift == TAG_FMT) begin
              if (chunk_len == 32'd0) begin
                fmt_seen = 1'b1;
                phase = PH_CHDR;
              end else begin
                phase = PH_FMT;
              end
            end else if (tag_shift == TAG_DATA) begin
              phase = PH_DONE;
              made = 1'b1;
              w.kind = KIND_REJECT;
              if (!fmt_seen) begin
                w.reject_reason = REJ_NO_FMT;
              end else if (fmt_code != FMT_PCM || bits != BITS_PCM16) begin
                w.reject_reason = REJ_NOT_PCM16;
              end else if (chans != CHAN_MONO && chans != CHAN_STEREO) begin
                w.reject_reason = REJ_BAD_CHAN;
              end else begin
                phase = PH_DATA;
                partial = '0;
                frame_pos = '0;
                w.kind = KIND_HEADER;
                w.rate_hz = rate;
                w.channel_count = chans;
                w.data_length = chunk_len;
              end
            end else begin
              phase = (chunk_len == 32'd0) ? PH_CHDR : PH_SKIP;
            end
          end else begin
            hdr_count++;
          end
        end
      end
      PH_FMT: begin
        pos = chunk_len - left_to_go;
        if (pos < 32'd2) begin
          fmt_code[8 * pos +: 8] = b;
        end else if (pos < 32'd4) begin
          chans[8 * (pos - 2) +: 8] = b;
        end else if (pos < 32'd8) begin
          rate[8 * (pos - 4) +: 8] = b;
        end else if (pos >= 32'd14 && pos < FMT_KEEP) begin
          bits[8 * (pos - 14) +: 8] = b;
        end
        left_to_go--;
        if (left_to_go == 32'd0) begin
          fmt_seen = 1'b1;
          phase = PH_CHDR;
        end
      end
      PH_SKIP: begin
        left_to_go--;
        if (left_to_go == 32'd0) begin
          phase = chunk_len[0] ? PH_PAD : PH_CHDR;
        end
      end
      PH_PAD: begin
        phase = PH_CHDR;
      end
      PH_DATA: begin
        fsize = (chans == CHAN_STEREO) ? 4 : 2;
        if (frame_pos == 2'd0 && left_to_go < fsize) begin
          phase = PH_DONE;
        end else begin
          if (frame_pos == 2'd0) begin
            partial = '0;
          end
          joined = {8'h00, partial} | (32'(b) << (8 * frame_pos));
          left_to_go--;
          if (frame_pos + 1 >= fsize) begin
            w.kind = KIND_FRAME;
            w.left_sample = joined[15:0];
            w.right_sample = (fsize == 4) ? joined[31:16] : joined[15:0];
            partial = '0;
            frame_pos = '0;
            if (left_to_go < fsize) begin
              w.last_frame = 1'b1;
              phase = PH_DONE;
            end
            made = 1'b1;
          end else begin
            partial = joined[23:0];
            frame_pos++;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      bad_fields++;
    end
  endtask

  always @(posedge clk) begin : watch_channels
    logic    made;
    result_t w;
    if (rst) begin
      reset_parser();
      due_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          $error("result word with no word expected: kind %0d", kind);
          bad_fields++;
        end else begin
          w = due_words.pop_front();
          check_field("kind", w.kind, kind);
          check_field("left_sample", w.left_sample, left_sample);
          check_field("right_sample", w.right_sample, right_sample);
          check_field("rate_hz", w.rate_hz, rate_hz);
          check_field("channel_count", w.channel_count, channel_count);
          check_field("data_length", w.data_length, data_length);
          check_field("reject_reason", w.reject_reason, reject_reason);
          check_field("last_frame", w.last_frame, last_frame);
        end
      end
      if (in_valid && in_ready) begin
        parse_wav_byte(data_byte, start_of_file, made, w);
        if (made) begin
          due_words.push_back(w);
        end
      end
    end
    mismatch_total <= bad_fields;
    words_due <= due_words.size();
  end

endmodule

// ===== verif/tb_wav_pcm16_stream_deframer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WAV PCM16 stream deframer testbench
// Feeds WAV files byte by byte, mostly well formed with random content and
// some broken or cut short, with random gaps on the input and stalls on the
// output, and leaves prediction and checking to a separate checker.
// ----------------------------------------------------------------------------
module tb_wav_pcm16_stream_deframer_unit;
  import wpsd_pkg::*;

  localparam int BYTE_TARGET  = 950;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_STALL   = 240;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         data_byte;
  logic               start_of_file;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         kind;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic [31:0]        rate_hz;
  logic [15:0]        channel_count;
  logic [31:0]        data_length;
  logic [1:0]         reject_reason;
  logic               last_frame;

  int                 mismatch_total;
  int                 words_due;
  int                 idle_cycles = 0;
  int                 bytes_sent = 0;
  int                 burst_left = 0;
  bit                 long_stall_done = 1'b0;
  logic [7:0]         file_bytes[$];

  wav_pcm16_stream_deframer_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .start_of_file(start_of_file),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .left_sample(left_sample), .right_sample(right_sample),
    .rate_hz(rate_hz), .channel_count(channel_count),
    .data_length(data_length), .reject_reason(reject_reason),
    .last_frame(last_frame)
  );

  wav_deframer_predict_check u_predict_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .start_of_file(start_of_file),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .left_sample(left_sample), .right_sample(right_sample),
    .rate_hz(rate_hz), .channel_count(channel_count),
    .data_length(data_length), .reject_reason(reject_reason),
    .last_frame(last_frame),
    .mismatch_total(mismatch_total), .words_due(words_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_be32(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(v[8 * i +: 8]);
  endtask

  task automatic push_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) file_bytes.push_back(v[8 * i +: 8]);
  endtask

  task automatic add_chunk_header(input logic [31:0] tag, input logic [31:0] len);
    push_be32(tag);
    push_le32(len);
  endtask

  task automatic add_filler_chunk();
    int len;
    len = $urandom_range(0, 5);
    add_chunk_header($urandom, len);
    repeat (len + (len % 2)) file_bytes.push_back(pick_byte());
  endtask

  task automatic add_fmt_chunk();
    logic [127:0] body;
    logic [15:0]  code;
    logic [15:0]  chans;
    logic [15:0]  bits;
    int           size;
    case ($urandom_range(0, 9))
      6: size = 18;
      7: size = 17;
      8: size = $urandom_range(1, 15);
      9: size = 0;
      default: size = 16;
    endcase
    code = ($urandom_range(0, 9) != 0) ? FMT_PCM : 16'($urandom);
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4: chans = CHAN_MONO;
      5, 6, 7, 8, 9: chans = CHAN_STEREO;
      10: chans = 16'd0;
      default: chans = 16'($urandom_range(3, 65535));
    endcase
    bits = ($urandom_range(0, 9) != 0) ? BITS_PCM16 : 16'($urandom);
    body = {bits, 16'($urandom), 32'($urandom), 32'($urandom), chans, code};
    add_chunk_header(TAG_FMT, size);
    for (int i = 0; i < size; i++) begin
      file_bytes.push_back((i < 16) ? body[8 * i +: 8] : pick_byte());
    end
  endtask

  task automatic offer_byte(input logic [7:0] value, input logic mark);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid <= 1'b1;
    data_byte <= value;
    start_of_file <= mark;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_file(input bit mark);
    foreach (file_bytes[i]) offer_byte(file_bytes[i], mark && i == 0);
  endtask

  initial begin : stimulus
    int          pick;
    int          spot;
    int          choice;
    int          data_count;
    int          cut;
    logic [31:0] data_len;
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= 8'h00;
    start_of_file <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // First file right after reset, with no start mark and a bad WAVE tag.
    file_bytes.delete();
    push_be32(TAG_RIFF);
    push_le32(32'h0000_0000);
    push_be32(TAG_WAVE ^ 32'h0000_0020);
    send_file(1'b0);
    // A data chunk before any fmt chunk.
    file_bytes.delete();
    push_be32(TAG_RIFF);
    push_le32(32'hFFFF_FFFF);
    push_be32(TAG_WAVE);
    add_chunk_header(TAG_DATA, 32'd4);
    send_file(1'b1);

    while (bytes_sent < BYTE_TARGET) begin
      file_bytes.delete();
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        repeat ($urandom_range(1, 24)) file_bytes.push_back(pick_byte());
      end else begin
        push_be32(TAG_RIFF);
        push_le32($urandom);
        push_be32(TAG_WAVE);
        if (pick < 14) begin
          spot = $urandom_range(0, 7);
          if (spot >= 4) begin
            spot = spot + 4;
          end
          file_bytes[spot] = file_bytes[spot] ^ 8'($urandom_range(1, 255));
        end
        repeat ($urandom_range(0, 2)) add_filler_chunk();
        if ($urandom_range(0, 19) != 0) begin
          add_fmt_chunk();
          if ($urandom_range(0, 7) == 0) begin
            add_filler_chunk();
            add_fmt_chunk();
          end
        end
        if ($urandom_range(0, 24) == 0) begin
          add_chunk_header($urandom, 32'h8000_0000 | $urandom);
          repeat (6) file_bytes.push_back(pick_byte());
        end else begin
          choice = $urandom_range(0, 19);
          data_len = (choice == 0) ? $urandom : $urandom_range(0, 24);
          data_count = (choice == 0) ? $urandom_range(0, 12) : int'(data_len);
          if (choice == 1) begin
            data_count = $urandom_range(0, data_len);
          end
          if (choice == 2) begin
            data_count = data_len + $urandom_range(1, 6);
          end
          add_chunk_header(TAG_DATA, data_len);
          repeat (data_count) file_bytes.push_back(pick_byte());
        end
        if ($urandom_range(0, 19) == 0) begin
          cut = $urandom_range(1, file_bytes.size() - 1);
          while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
      end
      send_file($urandom_range(0, 19) != 0);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_total == 0 && words_due == 0) begin
      $display("tb_wav_pcm16_stream_deframer_unit OK");
    end else begin
      $display("tb_wav_pcm16_stream_deframer_unit NOT OK");
    end
    $finish;
  end

  initial begin : receiver_pattern
    int       stall_cycles;
    int       mode_left;
    rx_mode_t mode;
    out_ready <= 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && !long_stall_done && out_valid && kind == KIND_HEADER &&
          data_length >= 32'd8) begin
        long_stall_done = 1'b1;
        out_ready <= 1'b0;
        stall_cycles = 0;
        while (stall_cycles < LONG_STALL) begin
          @(posedge clk);
          stall_cycles++;
        end
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 200);
        end
        mode_left--;
        case (mode)
          RX_OPEN: out_ready <= 1'b1;
          RX_COIN: out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 5) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_wav_pcm16_stream_deframer_unit NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
